### design/i2c_crm_pkg.sv
// Types, codes and constants shared by the I2C controller register model.
package i2c_crm_pkg;

    localparam int OPCODE_W = 4;
    localparam int UNIT_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 4;
    localparam int BYTE_W   = 8;

    // Register bit positions
    localparam int STATUS_STOP_BIT  = 0;
    localparam int STATUS_START_BIT = 1;
    localparam int STATUS_ACK_BIT   = 2;
    localparam int CTRL_READY_BIT   = 5;

    // Emulated devices (address is the 7-bit bus address)
    localparam logic [6:0]        DEV_LCD        = 7'h39;
    localparam logic [6:0]        DEV_CAMERA     = 7'h21;
    localparam logic [BYTE_W-1:0] LCD_CMD_ID     = 8'hBF;
    localparam logic [BYTE_W-1:0] LCD_ID_COUNT   = 8'h04;
    localparam logic [BYTE_W-1:0] LCD_ID_BYTE    = 8'h02;
    localparam logic [BYTE_W-1:0] CAM_CMD_ID_HI  = 8'h0A;
    localparam logic [BYTE_W-1:0] CAM_CMD_ID_LO  = 8'h0B;
    localparam logic [BYTE_W-1:0] CAM_CMD_VER    = 8'h11;
    localparam logic [BYTE_W-1:0] CAM_CMD_REG_A  = 8'h9C;
    localparam logic [BYTE_W-1:0] CAM_CMD_REG_B  = 8'h9D;
    localparam logic [BYTE_W-1:0] CAM_ID_HI      = 8'h77;
    localparam logic [BYTE_W-1:0] CAM_ID_LO      = 8'h42;
    localparam logic [BYTE_W-1:0] CAM_VER        = 8'h01;
    localparam logic [BYTE_W-1:0] CAM_REG_A      = 8'h1D;
    localparam logic [BYTE_W-1:0] CAM_REG_B      = 8'h2E;
    localparam logic [BYTE_W-1:0] BYTE_COUNT_MAX = 8'hFF;
    localparam logic [BYTE_W-1:0] COUNT_ADDRESS  = 8'h01;
    localparam logic [BYTE_W-1:0] COUNT_COMMAND  = 8'h02;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RD_FLAGS   = 4'd0,
        OP_RD_ENABLE  = 4'd1,
        OP_RD_DATA    = 4'd2,
        OP_RD_CONTROL = 4'd3,
        OP_RD_STATUS  = 4'd4,
        OP_WR_ENABLE  = 4'd5,
        OP_WR_ACK     = 4'd6,
        OP_WR_DATA    = 4'd7,
        OP_WR_CONTROL = 4'd8
    } opcode_t;

    typedef struct packed {
        logic [WORD_W-1:0]   write_value;
        logic [WORD_W-1:0]   write_mask;
        logic [UNIT_W-1:0]   unit;
        logic [OPCODE_W-1:0] opcode;
    } access_t;

    typedef struct packed {
        logic              irq_pulse;
        logic [WORD_W-1:0] read_value;
    } result_t;

    function automatic logic [BYTE_W-1:0] device_read(
        input logic [BYTE_W-1:0] address,
        input logic [BYTE_W-1:0] command,
        input logic [BYTE_W-1:0] count
    );
        logic [BYTE_W-1:0] data;
        data = '0;
        if (address[7:1] == DEV_LCD) begin
            if (command == LCD_CMD_ID && count == LCD_ID_COUNT)
                data = LCD_ID_BYTE;
        end else if (address[7:1] == DEV_CAMERA) begin
            case (command)
                CAM_CMD_ID_HI: data = CAM_ID_HI;
                CAM_CMD_ID_LO: data = CAM_ID_LO;
                CAM_CMD_VER:   data = CAM_VER;
                CAM_CMD_REG_A: data = CAM_REG_A;
                CAM_CMD_REG_B: data = CAM_REG_B;
                default:       data = '0;
            endcase
        end
        return data;
    endfunction

endpackage

### design/i2c_crm_core.sv
// Register file and combinational access logic of the I2C controller model.
module i2c_crm_core #(
    parameter int NUM_UNITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  i2c_crm_pkg::access_t req,
    output i2c_crm_pkg::result_t res
);

    localparam int WORD_W   = i2c_crm_pkg::WORD_W;
    localparam int STATUS_W = i2c_crm_pkg::STATUS_W;
    localparam int BYTE_W   = i2c_crm_pkg::BYTE_W;
    localparam int UNIT_W   = i2c_crm_pkg::UNIT_W;

    logic [WORD_W-1:0]   control_reg [NUM_UNITS];
    logic [WORD_W-1:0]   control_next [NUM_UNITS];
    logic [STATUS_W-1:0] status_reg [NUM_UNITS];
    logic [STATUS_W-1:0] status_next [NUM_UNITS];
    logic [WORD_W-1:0]   irq_enable_reg, irq_enable_next;
    logic [WORD_W-1:0]   irq_flag_reg, irq_flag_next;
    logic [BYTE_W-1:0]   byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]   device_address_reg, device_address_next;
    logic [BYTE_W-1:0]   device_command_reg, device_command_next;

    logic                unit_ok;
    logic [WORD_W-1:0]   sel_control, new_control;
    logic [STATUS_W-1:0] sel_status, new_status;
    logic [WORD_W-1:0]   masked_value;
    logic [WORD_W-1:0]   irq_bit;
    logic [BYTE_W-1:0]   count_inc;
    logic                xfer_op, xfer, irq;

    assign unit_ok      = {1'b0, req.unit} < (UNIT_W+1)'(NUM_UNITS);
    assign masked_value = req.write_value & req.write_mask;
    assign irq_bit      = WORD_W'(2) << req.unit;
    assign count_inc    = (byte_count_reg == i2c_crm_pkg::BYTE_COUNT_MAX) ?
                          byte_count_reg : byte_count_reg + BYTE_W'(1);

    // Pick the addressed unit's registers
    always_comb
    begin
        sel_control = '0;
        sel_status  = '0;
        for (int k = 0; k < NUM_UNITS; k++) begin
            if (req.unit == UNIT_W'(k))
            begin
                sel_control = control_reg[k];
                sel_status  = status_reg[k];
            end
        end
    end

    always_comb
    begin
        new_control = sel_control;
        new_status  = sel_status;
        if (req.opcode == i2c_crm_pkg::OP_WR_CONTROL)
        begin
            new_control = (sel_control & ~req.write_mask) |
                          (masked_value & ~WORD_W'(1));
            new_status  = (sel_status & ~req.write_mask[STATUS_W-1:0]) |
                          masked_value[STATUS_W-1:0];
        end
        xfer_op = req.opcode == i2c_crm_pkg::OP_RD_DATA ||
                  req.opcode == i2c_crm_pkg::OP_WR_DATA ||
                  req.opcode == i2c_crm_pkg::OP_WR_CONTROL;
        // Transfer step: a started unit acknowledges and drops data ready
        xfer = xfer_op && unit_ok && new_status[i2c_crm_pkg::STATUS_START_BIT];
        if (xfer)
        begin
            new_status[i2c_crm_pkg::STATUS_ACK_BIT]  = 1'b1;
            new_control[i2c_crm_pkg::CTRL_READY_BIT] = 1'b0;
        end
        irq = xfer && ((irq_enable_reg & irq_bit) != '0);
    end

    always_comb
    begin
        for (int k = 0; k < NUM_UNITS; k++) begin
            control_next[k] = control_reg[k];
            status_next[k]  = status_reg[k];
            if (unit_ok && req.unit == UNIT_W'(k))
            begin
                control_next[k] = new_control;
                status_next[k]  = new_status;
            end
        end
        irq_enable_next     = irq_enable_reg;
        irq_flag_next       = irq_flag_reg | (irq ? irq_bit : '0);
        byte_count_next     = byte_count_reg;
        device_address_next = device_address_reg;
        device_command_next = device_command_reg;
        res.read_value      = '0;
        res.irq_pulse       = irq;
        case (req.opcode)
            i2c_crm_pkg::OP_RD_FLAGS:   res.read_value = irq_flag_reg;
            i2c_crm_pkg::OP_RD_ENABLE:  res.read_value = irq_enable_reg;
            i2c_crm_pkg::OP_RD_CONTROL:
                if (unit_ok) res.read_value = sel_control;
            i2c_crm_pkg::OP_RD_STATUS:
                if (unit_ok) res.read_value = WORD_W'(sel_status);
            i2c_crm_pkg::OP_WR_ENABLE:
                irq_enable_next = (irq_enable_reg & ~req.write_mask) | masked_value;
            i2c_crm_pkg::OP_WR_ACK:
                irq_flag_next = irq_flag_reg & ~masked_value;
            i2c_crm_pkg::OP_RD_DATA:
                if (unit_ok)
                begin
                    byte_count_next = count_inc;
                    res.read_value  = WORD_W'(i2c_crm_pkg::device_read(
                        device_address_reg, device_command_reg, count_inc));
                end
            i2c_crm_pkg::OP_WR_DATA:
                if (unit_ok)
                begin
                    byte_count_next = count_inc;
                    if (count_inc == i2c_crm_pkg::COUNT_ADDRESS)
                        device_address_next = masked_value[BYTE_W-1:0];
                    else if (count_inc == i2c_crm_pkg::COUNT_COMMAND)
                        device_command_next = masked_value[BYTE_W-1:0];
                end
            i2c_crm_pkg::OP_WR_CONTROL:
                if (unit_ok && new_status[i2c_crm_pkg::STATUS_STOP_BIT])
                    byte_count_next = '0;
            default: res.read_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_UNITS; k++) begin
                control_reg[k] <= '0;
                status_reg[k]  <= '0;
            end
            irq_enable_reg     <= '0;
            irq_flag_reg       <= '0;
            byte_count_reg     <= '0;
            device_address_reg <= '0;
            device_command_reg <= '0;
        end
        else if (enable)
        begin
            for (int k = 0; k < NUM_UNITS; k++) begin
                control_reg[k] <= control_next[k];
                status_reg[k]  <= status_next[k];
            end
            irq_enable_reg     <= irq_enable_next;
            irq_flag_reg       <= irq_flag_next;
            byte_count_reg     <= byte_count_next;
            device_address_reg <= device_address_next;
            device_command_reg <= device_command_next;
        end
    end

endmodule

### design/i2c_controller_register_model.sv
// Top level of the I2C controller register model with stream request and result ports.
// Each request on the slave stream is one bus access to a four-unit I2C controller
// (register read, masked register write, or data byte to or from the emulated LCD and
// camera devices); exactly one result leaves on the master stream for every request, in
// order. Requests are taken one per clock: an input register holds the request, the
// register file and its update logic work it combinationally, and the result lands in
// an output register at the same edge that commits the new register state, so the next
// request already sees that state. A stalled result blocks the pipe only when the input
// register is full as well, so the design sustains one request per cycle while m_tready
// stays high. NUM_UNITS (1..4) sets how many units exist; control, status and data
// accesses to a missing unit read zero and change nothing.
module i2c_controller_register_model #(
    parameter int NUM_UNITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[3:0], unit[5:4], write_mask[37:6], write_value[69:38], zero pad[71:70]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[31:0], irq_pulse[32], zero pad[39:33]
    output logic [39:0] m_tdata
);

    localparam int ACCESS_W = $bits(i2c_crm_pkg::access_t);
    localparam int RESULT_W = $bits(i2c_crm_pkg::result_t);

    logic                 in_valid_reg, in_valid_next;
    i2c_crm_pkg::access_t in_req_reg;
    logic                 out_valid_reg, out_valid_next;
    i2c_crm_pkg::result_t out_res_reg;
    i2c_crm_pkg::result_t core_res;
    logic                 advance;
    logic                 take;

    // Advance the held request whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    i2c_crm_core #(
        .NUM_UNITS (NUM_UNITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (advance),
        .req    (in_req_reg),
        .res    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load the request on accept, the result on advance
    always_ff @(posedge clk)
    begin
        if (take)
            in_req_reg <= s_tdata[ACCESS_W-1:0];
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(40 - RESULT_W)'(0), out_res_reg};

endmodule

### design/i2c_crm_checker.sv
// Port-level checker for the I2C controller register model, bound to the top level.
module i2c_crm_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // Hold a stalled result steady
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every accepted request is followed by a valid result, though not necessarily its own
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result two cycles after request");

    // An empty output side never blocks requests
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

    // Pad bits above irq_pulse stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("result pad bits set");

endmodule

bind i2c_controller_register_model i2c_crm_port_checker u_i2c_crm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
